[rtl/core/sed_pkg.sv]
package sed_pkg;

    // decoder modes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESCAPE = 2'd1;
    localparam logic [1:0] MODE_HEX    = 2'd2;
    localparam logic [1:0] MODE_EQUALS = 2'd3;

    // status codes
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_BAD_ESCAPE = 4'd1;
    localparam logic [3:0] ST_BAD_HEX    = 4'd2;
    localparam logic [3:0] ST_HEX_CUT    = 4'd3;
    localparam logic [3:0] ST_TOO_LARGE  = 4'd4;
    localparam logic [3:0] ST_SURROGATE  = 4'd5;
    localparam logic [3:0] ST_NEWLINE    = 4'd6;
    localparam logic [3:0] ST_UNTERM     = 4'd7;
    localparam logic [3:0] ST_NEST_FULL  = 4'd8;

    // end kinds
    localparam logic [1:0] END_NONE   = 2'd0;
    localparam logic [1:0] END_QUOTE  = 2'd1;
    localparam logic [1:0] END_INTERP = 2'd2;
    localparam logic [1:0] END_ABORT  = 2'd3;

    // most results one byte can cause
    localparam int unsigned MAX_RESULTS = 5;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    // hex digit counts for \x, \u, \U
    localparam logic [3:0] HEX_BYTE_DIGITS  = 4'd2;
    localparam logic [3:0] HEX_SHORT_DIGITS = 4'd4;
    localparam logic [3:0] HEX_LONG_DIGITS  = 4'd8;

    // code point limits
    localparam logic [31:0] CP_MAX     = 32'h0010_FFFF;
    localparam logic [31:0] SURR_LO    = 32'h0000_D800;
    localparam logic [31:0] SURR_HI    = 32'h0000_DFFF;
    localparam logic [31:0] CP_1BYTE   = 32'h0000_007F;
    localparam logic [31:0] CP_2BYTE   = 32'h0000_07FF;
    localparam logic [31:0] CP_3BYTE   = 32'h0000_FFFF;
    localparam logic [7:0]  LEAD2      = 8'hC0;
    localparam logic [7:0]  LEAD3      = 8'hE0;
    localparam logic [7:0]  LEAD4      = 8'hF0;
    localparam logic [7:0]  CONT_MARK  = 8'h80;

    // characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_ESC    = 8'h1B;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data;
        logic [3:0] status;
        logic [1:0] end_kind;
    } sed_rec_t;

    typedef struct packed {
        sed_rec_t [MAX_RESULTS-1:0] rec;
        logic [CNT_W-1:0]           count;
    } sed_burst_t;

endpackage

[rtl/core/sed_decode.sv]
module sed_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         byte_in,
    input  logic               final_byte,
    input  logic               nesting_full,
    output sed_pkg::sed_burst_t burst
);

    logic [1:0]  mode_reg, mode_next;
    logic [3:0]  hex_needed_reg, hex_needed_next;
    logic [31:0] acc_reg, acc_next;
    logic        is_byte_reg, is_byte_next;

    // handling of a byte in normal mode
    logic              nh_put;
    sed_pkg::sed_rec_t nh_rec;
    logic              nh_end;
    logic [1:0]        nh_mode;

    logic              run_normal;
    logic              dig_ok;
    logic [3:0]        dig_val;
    logic [31:0]       acc_new;
    logic [3:0]        needed_dec;
    logic              esc_simple;
    logic [7:0]        esc_val;
    logic              end_seen;

    sed_pkg::sed_burst_t bn;

    function automatic sed_pkg::sed_rec_t mk_rec(input logic has, input logic [7:0] data,
                                                 input logic [3:0] st, input logic [1:0] ek);
        sed_pkg::sed_rec_t r;
        r.has_byte = has;
        r.data     = has ? data : 8'd0;
        r.status   = st;
        r.end_kind = ek;
        return r;
    endfunction

    always_comb
    begin
        dig_ok  = 1'b1;
        dig_val = 4'd0;
        if (byte_in >= 8'h30 && byte_in <= 8'h39)
        begin
            dig_val = 4'(byte_in - 8'h30);
        end
        else if (byte_in >= 8'h61 && byte_in <= 8'h66)
        begin
            dig_val = 4'(byte_in - 8'h57);
        end
        else if (byte_in >= 8'h41 && byte_in <= 8'h46)
        begin
            dig_val = 4'(byte_in - 8'h37);
        end
        else
        begin
            dig_ok = 1'b0;
        end
    end

    assign acc_new    = {acc_reg[27:0], dig_val};
    assign needed_dec = hex_needed_reg - 4'd1;

    // simple escapes
    always_comb
    begin
        esc_simple = 1'b1;
        esc_val    = 8'd0;
        unique case (byte_in)
            sed_pkg::CH_BSLASH: esc_val = sed_pkg::CH_BSLASH;
            8'h22:       esc_val = sed_pkg::CH_QUOTE;
            8'h3D:       esc_val = sed_pkg::CH_EQUALS;
            8'h30:       esc_val = 8'h00;
            8'h61:       esc_val = 8'h07;
            8'h62:       esc_val = 8'h08;
            8'h65:       esc_val = sed_pkg::CH_ESC;
            8'h66:       esc_val = 8'h0C;
            8'h6E:       esc_val = 8'h0A;
            8'h72:       esc_val = 8'h0D;
            8'h74:       esc_val = 8'h09;
            8'h76:       esc_val = 8'h0B;
            default:     esc_simple = 1'b0;
        endcase
    end

    always_comb
    begin
        nh_put  = 1'b0;
        nh_rec  = mk_rec(1'b0, 8'd0, sed_pkg::ST_OK, sed_pkg::END_NONE);
        nh_end  = 1'b0;
        nh_mode = sed_pkg::MODE_NORMAL;
        priority if (byte_in == sed_pkg::CH_QUOTE)
        begin
            nh_put = 1'b1;
            nh_end = 1'b1;
            nh_rec = mk_rec(1'b0, 8'd0, sed_pkg::ST_OK, sed_pkg::END_QUOTE);
        end
        else if (byte_in == sed_pkg::CH_CR)
        begin
            // dropped, but still ends the source
            nh_put = final_byte;
            nh_end = final_byte;
            nh_rec = mk_rec(1'b0, 8'd0, sed_pkg::ST_UNTERM, sed_pkg::END_ABORT);
        end
        else if (byte_in == sed_pkg::CH_LF)
        begin
            nh_put = 1'b1;
            nh_end = 1'b1;
            nh_rec = mk_rec(1'b0, 8'd0, sed_pkg::ST_NEWLINE, sed_pkg::END_ABORT);
        end
        else if (final_byte)
        begin
            nh_put = 1'b1;
            nh_end = 1'b1;
            nh_rec = mk_rec(1'b0, 8'd0, sed_pkg::ST_UNTERM, sed_pkg::END_ABORT);
        end
        else if (byte_in == sed_pkg::CH_EQUALS)
        begin
            nh_mode = sed_pkg::MODE_EQUALS;
        end
        else if (byte_in == sed_pkg::CH_BSLASH)
        begin
            nh_mode = sed_pkg::MODE_ESCAPE;
        end
        else
        begin
            nh_put = 1'b1;
            nh_rec = mk_rec(1'b1, byte_in, sed_pkg::ST_OK, sed_pkg::END_NONE);
        end
    end

    always_comb
    begin
        bn              = '0;
        mode_next       = mode_reg;
        hex_needed_next = hex_needed_reg;
        acc_next        = acc_reg;
        is_byte_next    = is_byte_reg;
        run_normal      = 1'b0;

        unique case (mode_reg)
            sed_pkg::MODE_NORMAL:
            begin
                run_normal = 1'b1;
            end
            sed_pkg::MODE_ESCAPE:
            begin
                mode_next = sed_pkg::MODE_NORMAL;
                if (esc_simple)
                begin
                    bn.rec[bn.count] = mk_rec(1'b1, esc_val, sed_pkg::ST_OK, sed_pkg::END_NONE);
                    bn.count = bn.count + 1'b1;
                end
                else if (byte_in == 8'h78 || byte_in == 8'h75 || byte_in == 8'h55)
                begin
                    priority if (byte_in == 8'h78)
                    begin
                        hex_needed_next = sed_pkg::HEX_BYTE_DIGITS;
                        is_byte_next    = 1'b1;
                    end
                    else if (byte_in == 8'h75)
                    begin
                        hex_needed_next = sed_pkg::HEX_SHORT_DIGITS;
                        is_byte_next    = 1'b0;
                    end
                    else
                    begin
                        hex_needed_next = sed_pkg::HEX_LONG_DIGITS;
                        is_byte_next    = 1'b0;
                    end
                    acc_next  = '0;
                    mode_next = sed_pkg::MODE_HEX;
                    if (final_byte)
                    begin
                        bn.rec[bn.count] = mk_rec(1'b1, 8'd0, sed_pkg::ST_HEX_CUT,
                                                  sed_pkg::END_NONE);
                        bn.count = bn.count + 1'b1;
                    end
                end
                else
                begin
                    bn.rec[bn.count] = mk_rec(1'b0, 8'd0, sed_pkg::ST_BAD_ESCAPE,
                                              sed_pkg::END_NONE);
                    bn.count = bn.count + 1'b1;
                end
                if (final_byte)
                begin
                    bn.rec[bn.count] = mk_rec(1'b0, 8'd0, sed_pkg::ST_UNTERM,
                                              sed_pkg::END_ABORT);
                    bn.count        = bn.count + 1'b1;
                    mode_next       = sed_pkg::MODE_NORMAL;
                    hex_needed_next = '0;
                    acc_next        = '0;
                    is_byte_next    = 1'b0;
                end
            end
            sed_pkg::MODE_HEX:
            begin
                if (hex_needed_reg == 4'd0 || hex_needed_reg > sed_pkg::HEX_LONG_DIGITS)
                begin
                    mode_next       = sed_pkg::MODE_NORMAL;
                    hex_needed_next = '0;
                    run_normal      = 1'b1;
                end
                else if (!dig_ok)
                begin
                    // NUL for the broken escape, then the byte is taken as body text
                    bn.rec[bn.count] = mk_rec(1'b1, 8'd0, sed_pkg::ST_BAD_HEX,
                                              sed_pkg::END_NONE);
                    bn.count        = bn.count + 1'b1;
                    mode_next       = sed_pkg::MODE_NORMAL;
                    hex_needed_next = '0;
                    acc_next        = '0;
                    run_normal      = 1'b1;
                end
                else
                begin
                    acc_next        = acc_new;
                    hex_needed_next = needed_dec;
                    if (needed_dec == 4'd0)
                    begin
                        if (is_byte_reg)
                        begin
                            bn.rec[bn.count] = mk_rec(1'b1, acc_new[7:0], sed_pkg::ST_OK,
                                                      sed_pkg::END_NONE);
                            bn.count = bn.count + 1'b1;
                        end
                        else if (acc_new > sed_pkg::CP_MAX)
                        begin
                            bn.rec[bn.count] = mk_rec(1'b0, 8'd0, sed_pkg::ST_TOO_LARGE,
                                                      sed_pkg::END_NONE);
                            bn.count = bn.count + 1'b1;
                        end
                        else if (acc_new >= sed_pkg::SURR_LO && acc_new <= sed_pkg::SURR_HI)
                        begin
                            bn.rec[bn.count] = mk_rec(1'b0, 8'd0, sed_pkg::ST_SURROGATE,
                                                      sed_pkg::END_NONE);
                            bn.count = bn.count + 1'b1;
                        end
                        else if (acc_new <= sed_pkg::CP_1BYTE)
                        begin
                            bn.rec[0] = mk_rec(1'b1, acc_new[7:0], sed_pkg::ST_OK,
                                               sed_pkg::END_NONE);
                            bn.count  = 3'd1;
                        end
                        else if (acc_new <= sed_pkg::CP_2BYTE)
                        begin
                            bn.rec[0] = mk_rec(1'b1, sed_pkg::LEAD2 | {3'd0, acc_new[10:6]},
                                               sed_pkg::ST_OK, sed_pkg::END_NONE);
                            bn.rec[1] = mk_rec(1'b1, sed_pkg::CONT_MARK | {2'd0, acc_new[5:0]},
                                               sed_pkg::ST_OK, sed_pkg::END_NONE);
                            bn.count  = 3'd2;
                        end
                        else if (acc_new <= sed_pkg::CP_3BYTE)
                        begin
                            bn.rec[0] = mk_rec(1'b1, sed_pkg::LEAD3 | {4'd0, acc_new[15:12]},
                                               sed_pkg::ST_OK, sed_pkg::END_NONE);
                            bn.rec[1] = mk_rec(1'b1, sed_pkg::CONT_MARK | {2'd0, acc_new[11:6]},
                                               sed_pkg::ST_OK, sed_pkg::END_NONE);
                            bn.rec[2] = mk_rec(1'b1, sed_pkg::CONT_MARK | {2'd0, acc_new[5:0]},
                                               sed_pkg::ST_OK, sed_pkg::END_NONE);
                            bn.count  = 3'd3;
                        end
                        else
                        begin
                            bn.rec[0] = mk_rec(1'b1, sed_pkg::LEAD4 | {5'd0, acc_new[20:18]},
                                               sed_pkg::ST_OK, sed_pkg::END_NONE);
                            bn.rec[1] = mk_rec(1'b1,
                                               sed_pkg::CONT_MARK | {2'd0, acc_new[17:12]},
                                               sed_pkg::ST_OK, sed_pkg::END_NONE);
                            bn.rec[2] = mk_rec(1'b1, sed_pkg::CONT_MARK | {2'd0, acc_new[11:6]},
                                               sed_pkg::ST_OK, sed_pkg::END_NONE);
                            bn.rec[3] = mk_rec(1'b1, sed_pkg::CONT_MARK | {2'd0, acc_new[5:0]},
                                               sed_pkg::ST_OK, sed_pkg::END_NONE);
                            bn.count  = 3'd4;
                        end
                        mode_next = sed_pkg::MODE_NORMAL;
                        acc_next  = '0;
                    end
                    else if (final_byte)
                    begin
                        bn.rec[bn.count] = mk_rec(1'b1, 8'd0, sed_pkg::ST_HEX_CUT,
                                                  sed_pkg::END_NONE);
                        bn.count = bn.count + 1'b1;
                    end
                    if (final_byte)
                    begin
                        bn.rec[bn.count] = mk_rec(1'b0, 8'd0, sed_pkg::ST_UNTERM,
                                                  sed_pkg::END_ABORT);
                        bn.count        = bn.count + 1'b1;
                        mode_next       = sed_pkg::MODE_NORMAL;
                        hex_needed_next = '0;
                        acc_next        = '0;
                        is_byte_next    = 1'b0;
                    end
                end
            end
            sed_pkg::MODE_EQUALS:
            begin
                mode_next = sed_pkg::MODE_NORMAL;
                if (byte_in == sed_pkg::CH_LPAREN)
                begin
                    if (nesting_full)
                    begin
                        bn.rec[0] = mk_rec(1'b0, 8'd0, sed_pkg::ST_NEST_FULL,
                                           sed_pkg::END_ABORT);
                    end
                    else
                    begin
                        bn.rec[0] = mk_rec(1'b0, 8'd0, sed_pkg::ST_OK, sed_pkg::END_INTERP);
                    end
                    bn.count        = 3'd1;
                    hex_needed_next = '0;
                    acc_next        = '0;
                    is_byte_next    = 1'b0;
                end
                else
                begin
                    bn.rec[0] = mk_rec(1'b1, sed_pkg::CH_EQUALS, sed_pkg::ST_OK,
                                       sed_pkg::END_NONE);
                    bn.count   = 3'd1;
                    run_normal = 1'b1;
                end
            end
            default:
            begin
                run_normal = 1'b1;
            end
        endcase

        if (run_normal)
        begin
            if (nh_put)
            begin
                bn.rec[bn.count] = nh_rec;
                bn.count = bn.count + 1'b1;
            end
            if (nh_end)
            begin
                mode_next       = sed_pkg::MODE_NORMAL;
                hex_needed_next = '0;
                acc_next        = '0;
                is_byte_next    = 1'b0;
            end
            else
            begin
                mode_next = nh_mode;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= sed_pkg::MODE_NORMAL;
            hex_needed_reg <= '0;
            acc_reg        <= '0;
            is_byte_reg    <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            hex_needed_reg <= hex_needed_next;
            acc_reg        <= acc_next;
            is_byte_reg    <= is_byte_next;
        end
    end

    assign burst    = bn;
    assign end_seen = (bn.count != '0) &&
                      (bn.rec[bn.count - 1'b1].end_kind != sed_pkg::END_NONE);

    // waiting for hex digits always has a digit count in range
    a_hex_count: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == sed_pkg::MODE_HEX |-> hex_needed_reg != 4'd0 &&
                                          hex_needed_reg <= sed_pkg::HEX_LONG_DIGITS)
        else $error("hex mode with digit count out of range");

    // a string end leaves the decoder clean for the next body
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_seen |=> mode_reg == sed_pkg::MODE_NORMAL &&
                               hex_needed_reg == 4'd0 && acc_reg == 32'd0 && !is_byte_reg)
        else $error("string end did not clear decoder state");

endmodule

[rtl/core/sed_burst.sv]
module sed_burst (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  sed_pkg::sed_burst_t burst_in,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output sed_pkg::sed_rec_t   out_rec,
    output logic                out_last
);

    sed_pkg::sed_rec_t [sed_pkg::MAX_RESULTS-1:0] buf_reg, buf_next;
    logic [sed_pkg::CNT_W-1:0]                    cnt_reg, cnt_next;
    logic                                         out_fire;

    assign out_valid = cnt_reg != '0;
    assign out_fire  = out_valid && out_ready;
    assign out_last  = cnt_reg == sed_pkg::CNT_W'(1);
    assign out_rec   = buf_reg[0];
    // next burst may load as soon as the last pending beat leaves
    assign in_ready  = (cnt_reg == '0) || (out_last && out_ready);

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            buf_next = burst_in.rec;
            cnt_next = burst_in.count;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < sed_pkg::MAX_RESULTS - 1; i++)
            begin
                buf_next[i] = buf_reg[i+1];
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= sed_pkg::CNT_W'(sed_pkg::MAX_RESULTS))
        else $error("burst count out of range");

    a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && cnt_reg > sed_pkg::CNT_W'(1) |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("burst drain lost or repeated a beat");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> cnt_reg == '0 || (cnt_reg == sed_pkg::CNT_W'(1) && out_fire))
        else $error("burst loaded over pending beats");

endmodule

[rtl/core/string_escape_decoder.sv]
// string literal body decoder
//
// s_axis: one raw body byte per beat. tdata[7:0] is the byte, tlast marks the
// last byte of the source, tuser says the interpolation nesting is already full.
// m_axis: decoded results, one per beat. tuser is has_byte; tdata carries the
// decoded byte, status and end kind; tlast marks the final result of an input
// byte. An input byte makes zero to five results (a \U escape with the source
// ending on its last digit gives four UTF-8 bytes plus the unterminated end).
//
// the first result of a byte is registered and appears in the cycle after its beat.
// throughput: one byte per cycle while every byte yields at most one result and the
// receiver is ready; a byte with several results holds the result register until
// all have left; the next byte is taken in the cycle its last result leaves, so the
// rate is set by the single-beat output port. Bytes with no result pass at one per
// cycle. When the receiver stalls, the pending results hold and s_axis_tready falls
// until only the final one remains and is taken.
// reset: the decoder returns to normal body mode with hex state cleared and no
// results pending.
module string_escape_decoder (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_in
    input  logic        s_axis_tlast,   // final_byte
    input  logic        s_axis_tuser,   // nesting_full

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // decoded_byte[7:0], status[11:8], end_kind[13:12], zero
    output logic        m_axis_tlast,   // last
    output logic        m_axis_tuser    // has_byte
);

    logic                accept;
    sed_pkg::sed_burst_t burst;
    sed_pkg::sed_rec_t   out_rec;

    // a beat is taken only when the result buffer can load its burst
    assign accept = s_axis_tvalid && s_axis_tready;

    // decode state and per-byte result burst
    sed_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .byte_in      (s_axis_tdata),
        .final_byte   (s_axis_tlast),
        .nesting_full (s_axis_tuser),
        .burst        (burst)
    );

    // result register, drains the burst one beat at a time
    sed_burst u_burst (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .burst_in  (burst),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rec   (out_rec),
        .out_last  (m_axis_tlast)
    );

    // pack result fields, lowest first
    assign m_axis_tdata = {2'b00, out_rec.end_kind, out_rec.status, out_rec.data};
    assign m_axis_tuser = out_rec.has_byte;

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one decoded result as it should leave the master side
    typedef struct {
        logic       has_byte;
        logic [7:0] data;
        logic [3:0] status;
        logic [1:0] end_kind;
        logic       last;
    } decoded_item_t;

    // keeps its own copy of the decoder state and the queue of results still owed
    class decode_scoreboard;
        logic [1:0]    mode;
        logic [3:0]    hex_needed;
        logic [31:0]   hex_acc;
        logic          hex_is_byte;
        decoded_item_t burst[$];
        decoded_item_t decoded_due[$];
        int            mismatches;

        function new();
            mode        = sed_pkg::MODE_NORMAL;
            hex_needed  = 4'd0;
            hex_acc     = 32'd0;
            hex_is_byte = 1'b0;
            mismatches  = 0;
        endfunction

        function int pending();
            return decoded_due.size();
        endfunction

        function void add_result(logic has, logic [7:0] b, logic [3:0] st, logic [1:0] ek);
            decoded_item_t item;
            if (burst.size() >= sed_pkg::MAX_RESULTS)
                return;
            item.has_byte = has;
            item.data     = has ? b : 8'h00;
            item.status   = st;
            item.end_kind = ek;
            item.last     = 1'b0;
            burst = {burst, item};
        endfunction

        // any end of the string puts the decoder back to a clean body mode
        function void finish_body(logic [3:0] st, logic [1:0] ek);
            add_result(1'b0, 8'h00, st, ek);
            mode        = sed_pkg::MODE_NORMAL;
            hex_needed  = 4'd0;
            hex_acc     = 32'd0;
            hex_is_byte = 1'b0;
        endfunction

        function int hex_nibble(logic [7:0] b);
            if (b >= "0" && b <= "9")
                return b - "0";
            if (b >= "a" && b <= "f")
                return b - "a" + 10;
            if (b >= "A" && b <= "F")
                return b - "A" + 10;
            return -1;
        endfunction

        function void encode_code_point(logic [31:0] cp);
            if (cp > sed_pkg::CP_MAX)
                add_result(1'b0, 8'h00, sed_pkg::ST_TOO_LARGE, sed_pkg::END_NONE);
            else if (cp >= sed_pkg::SURR_LO && cp <= sed_pkg::SURR_HI)
                add_result(1'b0, 8'h00, sed_pkg::ST_SURROGATE, sed_pkg::END_NONE);
            else if (cp <= sed_pkg::CP_1BYTE)
                add_result(1'b1, cp[7:0], sed_pkg::ST_OK, sed_pkg::END_NONE);
            else if (cp <= sed_pkg::CP_2BYTE)
            begin
                add_result(1'b1, sed_pkg::LEAD2 | {3'b000, cp[10:6]},
                           sed_pkg::ST_OK, sed_pkg::END_NONE);
                add_result(1'b1, sed_pkg::CONT_MARK | {2'b00, cp[5:0]},
                           sed_pkg::ST_OK, sed_pkg::END_NONE);
            end
            else if (cp <= sed_pkg::CP_3BYTE)
            begin
                add_result(1'b1, sed_pkg::LEAD3 | {4'b0000, cp[15:12]},
                           sed_pkg::ST_OK, sed_pkg::END_NONE);
                add_result(1'b1, sed_pkg::CONT_MARK | {2'b00, cp[11:6]},
                           sed_pkg::ST_OK, sed_pkg::END_NONE);
                add_result(1'b1, sed_pkg::CONT_MARK | {2'b00, cp[5:0]},
                           sed_pkg::ST_OK, sed_pkg::END_NONE);
            end
            else
            begin
                add_result(1'b1, sed_pkg::LEAD4 | {5'b00000, cp[20:18]},
                           sed_pkg::ST_OK, sed_pkg::END_NONE);
                add_result(1'b1, sed_pkg::CONT_MARK | {2'b00, cp[17:12]},
                           sed_pkg::ST_OK, sed_pkg::END_NONE);
                add_result(1'b1, sed_pkg::CONT_MARK | {2'b00, cp[11:6]},
                           sed_pkg::ST_OK, sed_pkg::END_NONE);
                add_result(1'b1, sed_pkg::CONT_MARK | {2'b00, cp[5:0]},
                           sed_pkg::ST_OK, sed_pkg::END_NONE);
            end
        endfunction

        function void body_byte(logic [7:0] b, logic fin);
            if (b == sed_pkg::CH_QUOTE)
                finish_body(sed_pkg::ST_OK, sed_pkg::END_QUOTE);
            else if (b == sed_pkg::CH_CR)
            begin
                if (fin)
                    finish_body(sed_pkg::ST_UNTERM, sed_pkg::END_ABORT);
            end
            else if (b == sed_pkg::CH_LF)
                finish_body(sed_pkg::ST_NEWLINE, sed_pkg::END_ABORT);
            else if (fin)
                finish_body(sed_pkg::ST_UNTERM, sed_pkg::END_ABORT);
            else if (b == sed_pkg::CH_EQUALS)
                mode = sed_pkg::MODE_EQUALS;
            else if (b == sed_pkg::CH_BSLASH)
                mode = sed_pkg::MODE_ESCAPE;
            else
                add_result(1'b1, b, sed_pkg::ST_OK, sed_pkg::END_NONE);
        endfunction

        function void escape_byte(logic [7:0] b, logic fin);
            logic [7:0] v;
            logic [3:0] digits;
            v      = 8'h00;
            digits = 4'd0;
            mode   = sed_pkg::MODE_NORMAL;
            case (b)
                sed_pkg::CH_BSLASH, sed_pkg::CH_QUOTE, sed_pkg::CH_EQUALS: v = b;
                "0": v = 8'h00;
                "a": v = 8'h07;
                "b": v = 8'h08;
                "e": v = sed_pkg::CH_ESC;
                "f": v = 8'h0C;
                "n": v = sed_pkg::CH_LF;
                "r": v = sed_pkg::CH_CR;
                "t": v = 8'h09;
                "v": v = 8'h0B;
                "x": digits = sed_pkg::HEX_BYTE_DIGITS;
                "u": digits = sed_pkg::HEX_SHORT_DIGITS;
                "U": digits = sed_pkg::HEX_LONG_DIGITS;
                default:
                begin
                    add_result(1'b0, 8'h00, sed_pkg::ST_BAD_ESCAPE, sed_pkg::END_NONE);
                    if (fin)
                        finish_body(sed_pkg::ST_UNTERM, sed_pkg::END_ABORT);
                    return;
                end
            endcase
            if (digits == 4'd0)
            begin
                add_result(1'b1, v, sed_pkg::ST_OK, sed_pkg::END_NONE);
                if (fin)
                    finish_body(sed_pkg::ST_UNTERM, sed_pkg::END_ABORT);
                return;
            end
            hex_needed  = digits;
            hex_is_byte = (digits == sed_pkg::HEX_BYTE_DIGITS);
            hex_acc     = 32'd0;
            mode        = sed_pkg::MODE_HEX;
            if (fin)
            begin
                add_result(1'b1, 8'h00, sed_pkg::ST_HEX_CUT, sed_pkg::END_NONE);
                finish_body(sed_pkg::ST_UNTERM, sed_pkg::END_ABORT);
            end
        endfunction

        function void hex_byte(logic [7:0] b, logic fin);
            int d;
            d = hex_nibble(b);
            // a stray character ends the escape with a nul and is then read as body text
            if (d < 0)
            begin
                add_result(1'b1, 8'h00, sed_pkg::ST_BAD_HEX, sed_pkg::END_NONE);
                mode       = sed_pkg::MODE_NORMAL;
                hex_needed = 4'd0;
                hex_acc    = 32'd0;
                body_byte(b, fin);
                return;
            end
            hex_acc    = (hex_acc << 4) | (d & 15);
            hex_needed = hex_needed - 4'd1;
            if (hex_needed == 4'd0)
            begin
                if (hex_is_byte)
                    add_result(1'b1, hex_acc[7:0], sed_pkg::ST_OK, sed_pkg::END_NONE);
                else
                    encode_code_point(hex_acc);
                mode    = sed_pkg::MODE_NORMAL;
                hex_acc = 32'd0;
                if (fin)
                    finish_body(sed_pkg::ST_UNTERM, sed_pkg::END_ABORT);
            end
            else if (fin)
            begin
                add_result(1'b1, 8'h00, sed_pkg::ST_HEX_CUT, sed_pkg::END_NONE);
                finish_body(sed_pkg::ST_UNTERM, sed_pkg::END_ABORT);
            end
        endfunction

        // accepted source beat: work out every result it owes
        function void note_source_byte(logic [7:0] b, logic fin, logic full);
            decoded_item_t item;
            burst.delete();
            case (mode)
                sed_pkg::MODE_ESCAPE: escape_byte(b, fin);
                sed_pkg::MODE_HEX:
                begin
                    if (hex_needed == 4'd0 || hex_needed > sed_pkg::HEX_LONG_DIGITS)
                    begin
                        mode       = sed_pkg::MODE_NORMAL;
                        hex_needed = 4'd0;
                        body_byte(b, fin);
                    end
                    else
                        hex_byte(b, fin);
                end
                sed_pkg::MODE_EQUALS:
                begin
                    mode = sed_pkg::MODE_NORMAL;
                    if (b == sed_pkg::CH_LPAREN)
                    begin
                        if (full)
                            finish_body(sed_pkg::ST_NEST_FULL, sed_pkg::END_ABORT);
                        else
                            finish_body(sed_pkg::ST_OK, sed_pkg::END_INTERP);
                    end
                    else
                    begin
                        add_result(1'b1, sed_pkg::CH_EQUALS, sed_pkg::ST_OK,
                                   sed_pkg::END_NONE);
                        body_byte(b, fin);
                    end
                end
                default: body_byte(b, fin);
            endcase
            for (int i = 0; i < burst.size(); i++)
            begin
                item      = burst[i];
                item.last = (i == burst.size() - 1);
                decoded_due = {decoded_due, item};
            end
        endfunction

        function void flag_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v)
            begin
                $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
                mismatches++;
            end
        endfunction

        // accepted result beat: compare with the oldest owed result
        function void check_decoded(logic has, logic [15:0] tdata, logic last);
            decoded_item_t want;
            if (decoded_due.size() == 0)
            begin
                $display("%0t: result beat with nothing owed: has_byte %0b tdata %04h last %0b",
                         $time, has, tdata, last);
                mismatches++;
                return;
            end
            want = decoded_due.pop_front();
            flag_field("has_byte", want.has_byte, has);
            flag_field("decoded_byte", want.data, tdata[7:0]);
            flag_field("status", want.status, tdata[11:8]);
            flag_field("end_kind", want.end_kind, tdata[13:12]);
            flag_field("tdata pad", 32'd0, tdata[15:14]);
            flag_field("last", want.last, last);
        endfunction
    endclass

    // cycles with no beat on either side before the run is called hung
    localparam int STALL_LIMIT = 4000;
    // random source bytes after the directed part
    localparam int RANDOM_BYTES = 320;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;  // byte_in
    logic        s_axis_tlast = 1'b0;   // final_byte
    logic        s_axis_tuser = 1'b0;   // nesting_full

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // decoded_byte, status, end_kind, zero pad
    logic        m_axis_tlast;          // last
    logic        m_axis_tuser;          // has_byte

    decode_scoreboard sb;

    int burst_left = 0;     // source beats left in the current burst
    int sent_bytes = 0;
    int next_pause = 0;
    int stall_style = 0;    // receiver behavior for the current stretch
    int stall_phase = 0;
    int idle_cycles = 0;

    string_escape_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // both sides are sampled at the edge, source beat first since results are registered behind it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_source_byte(s_axis_tdata, s_axis_tlast, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_decoded(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
    end

    // receiver: stretches of always ready, coin flips, rare stalls and long stalls
    always @(posedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_style <= $urandom_range(0, 3);
            stall_phase <= $urandom_range(16, 96);
        end
        else
            stall_phase <= stall_phase - 1;
        case (stall_style)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            2: m_axis_tready <= ($urandom_range(0, 7) != 0);
            default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // watchdog on beat activity
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("string_escape_decoder: mismatch");
            $finish;
        end
    end

    // one source beat, with a random gap when a burst runs out
    task automatic send_byte(input logic [7:0] b, input logic fin, input logic full);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        s_axis_tuser  <= full;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_bytes++;
    endtask

    // text with the source end flag optionally on its last character
    task automatic send_text(input string s, input logic fin_last, input logic full);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], fin_last && (i == s.len() - 1), full);
    endtask

    // hold the source until every owed result has left
    task automatic drain_decoder();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // one well-formed piece of string body with random content, sometimes broken
    task automatic send_random_token();
        logic [7:0]  tok[$];
        logic [7:0]  b;
        logic [31:0] cp;
        logic [31:0] cp_edges[12];
        string       esc_set;
        int          kind;
        int          digits;
        int          bad_at;
        int          cut;
        int          nib;
        cp_edges = '{32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hD7FF, 32'hD800,
                     32'hDFFF, 32'hE000, 32'hFFFF, 32'h10000, 32'h10FFFF, 32'h110000};
        esc_set  = "\\\"=0abefnrtv";
        kind     = $urandom_range(0, 15);
        if (kind <= 3)
            tok = {tok, 8'($urandom_range(0, 255))};
        else if (kind <= 5)
        begin
            tok = {tok, sed_pkg::CH_BSLASH};
            tok = {tok, 8'(esc_set[$urandom_range(0, esc_set.len() - 1)])};
        end
        else if (kind == 6)
        begin
            tok = {tok, sed_pkg::CH_BSLASH};
            tok = {tok, 8'($urandom_range(0, 255))};
        end
        else if (kind <= 11)
        begin
            // \x, \u or \U with a code point picked by utf-8 length and limit cases
            case ($urandom_range(0, 6))
                0: cp = $urandom_range(0, 32'h7F);
                1: cp = $urandom_range(32'h80, 32'h7FF);
                2: cp = $urandom_range(32'h800, 32'hFFFF);
                3: cp = $urandom_range(32'h10000, sed_pkg::CP_MAX);
                4: cp = $urandom_range(sed_pkg::SURR_LO, sed_pkg::SURR_HI);
                5: cp = $urandom_range(32'h110000, 32'hFFFF_FFFF);
                default: cp = cp_edges[$urandom_range(0, 11)];
            endcase
            tok = {tok, sed_pkg::CH_BSLASH};
            case ($urandom_range(0, 2))
                0:
                begin
                    tok = {tok, 8'("x")};
                    digits = sed_pkg::HEX_BYTE_DIGITS;
                    cp = $urandom_range(0, 255);
                end
                1:
                begin
                    tok = {tok, 8'("u")};
                    digits = sed_pkg::HEX_SHORT_DIGITS;
                end
                default:
                begin
                    tok = {tok, 8'("U")};
                    digits = sed_pkg::HEX_LONG_DIGITS;
                end
            endcase
            bad_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, digits - 1) : -1;
            for (int i = 0; i < digits; i++)
            begin
                nib = (cp >> (4 * (digits - 1 - i))) & 15;
                if (i == bad_at)
                begin
                    do
                        b = $urandom_range(0, 255);
                    while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
                           (b >= "A" && b <= "F"));
                    tok = {tok, b};
                    break;
                end
                if (nib < 10)
                    tok = {tok, 8'("0" + nib)};
                else if ($urandom_range(0, 1))
                    tok = {tok, 8'("a" + nib - 10)};
                else
                    tok = {tok, 8'("A" + nib - 10)};
            end
        end
        else if (kind <= 13)
        begin
            tok = {tok, sed_pkg::CH_EQUALS};
            tok = {tok, 8'(($urandom_range(0, 2) != 0) ? sed_pkg::CH_LPAREN
                                                        : $urandom_range(0, 255))};
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: tok = {tok, sed_pkg::CH_QUOTE};
                1: tok = {tok, sed_pkg::CH_LF};
                2: tok = {tok, sed_pkg::CH_CR};
                default: tok = {tok, sed_pkg::CH_EQUALS};
            endcase
        end
        // now and then the source ends somewhere inside the piece
        cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, tok.size() - 1) : tok.size();
        for (int i = 0; i < tok.size() && i <= cut; i++)
            send_byte(tok[i], i == cut, $urandom_range(0, 1));
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte extremes, nesting flag on an ordinary byte
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        // interpolation refused, then opened
        send_text("=(", 1'b0, 1'b1);
        send_text("=(", 1'b0, 1'b0);
        // lone equals falls back to a byte
        send_text("=a", 1'b0, 1'b0);
        send_text("\\n", 1'b0, 1'b0);
        // unknown escape
        send_text("\\q", 1'b0, 1'b0);
        // stray character inside \x, then reprocessed
        send_text("\\xG", 1'b0, 1'b0);
        // source ends before the hex digits are in
        send_text("\\x4", 1'b1, 1'b0);
        // cr skipped, then quote and newline endings
        send_byte(sed_pkg::CH_CR, 1'b0, 1'b0);
        send_byte(sed_pkg::CH_QUOTE, 1'b0, 1'b0);
        send_byte(sed_pkg::CH_LF, 1'b0, 1'b0);
        // source ends on a plain byte and on a pending equals
        send_byte("a", 1'b1, 1'b0);
        send_byte(sed_pkg::CH_EQUALS, 1'b1, 1'b0);

        next_pause = sent_bytes + $urandom_range(60, 140);
        while (sent_bytes < 23 + RANDOM_BYTES)
        begin
            send_random_token();
            if (sent_bytes >= next_pause)
            begin
                drain_decoder();
                next_pause = sent_bytes + $urandom_range(60, 140);
            end
        end

        drain_decoder();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("string_escape_decoder: match");
        else
            $display("string_escape_decoder: mismatch");
        $finish;
    end

endmodule
